// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold at the same clock edge as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rational_arith_reduce check failed");

// The consequent must hold at the clock edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rational_arith_reduce check failed");

`endif

// ----- src/rar_pkg.sv -----
package rar_pkg;

   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int OPCODE_W          = 3;
   localparam int RES_W             = 33;
   localparam int RSP_DATA_W        = ((2 * RES_W + 7) / 8) * 8;

   localparam logic [OPCODE_W-1:0] OP_REDUCE   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD      = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_SUBTRACT = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_MULTIPLY = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_DIVIDE   = 3'd4;

   // Which of the three partial products a multiply step produces.
   typedef enum logic [1:0] {
      SEL_P0 = 2'd0,
      SEL_P1 = 2'd1,
      SEL_P2 = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        gcd_step;
      logic        div_start;
      logic        div_step;
      logic        mul_step;
      mul_sel_type mul_sel;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic is_reduce;
      logic is_arith;
      logic zero_both;
      logic gcd_done;
      logic div_last;
   } status_type;

endpackage

// ----- src/rar_ctrl.sv -----
module rar_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output rar_pkg::cmd_type    cmd,
   input  rar_pkg::status_type status
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DISPATCH = 8'b0000_0010,
      ST_GCD      = 8'b0000_0100,
      ST_DIV      = 8'b0000_1000,
      ST_MUL0     = 8'b0001_0000,
      ST_MUL1     = 8'b0010_0000,
      ST_MUL2     = 8'b0100_0000,
      ST_FIN      = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.is_reduce && !status.zero_both) begin
               state_in = ST_GCD;
            end else if (status.is_arith) begin
               state_in = ST_MUL0;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_GCD: begin
            if (status.gcd_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_MUL0: begin
            cmd.mul_step = 1'b1;
            cmd.mul_sel  = rar_pkg::SEL_P0;
            state_in     = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_step = 1'b1;
            cmd.mul_sel  = rar_pkg::SEL_P1;
            state_in     = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_step = 1'b1;
            cmd.mul_sel  = rar_pkg::SEL_P2;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            // The result register is free once its previous item is taken.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- src/rar_dp.sv -----
module rar_dp #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF,
   localparam int ReqDataW = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
   input  logic                              clock,
   input  rar_pkg::cmd_type                  cmd,
   output rar_pkg::status_type               status,
   input  logic [rar_pkg::OPCODE_W-1:0]      req_tuser,
   input  logic [ReqDataW-1:0]               req_tdata,
   output logic [rar_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser
);

   localparam int W  = OPERAND_WIDTH;
   localparam int KW = $clog2(W);
   localparam int RW = rar_pkg::RES_W;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
      return x[W-1] ? (~x + 1'b1) : x;
   endfunction

   logic [rar_pkg::OPCODE_W-1:0] op_ff;
   logic signed [W-1:0]          na_ff, da_ff, nb_ff, db_ff;
   logic [W-1:0]                 ga_ff, gb_ff;
   logic [KW-1:0]                k_ff;
   logic [W-1:0]                 div_ff;
   logic [W-1:0]                 quo_n_ff, quo_d_ff, rem_n_ff, rem_d_ff;
   logic [KW-1:0]                cnt_ff;
   logic [RW-1:0]                p0_ff, p1_ff, p2_ff;
   logic [RW-1:0]                res_num_ff, res_den_ff;
   logic                         err_ff;

   logic [W:0]                   trial_n, trial_d;
   logic signed [W-1:0]          mul_x, mul_y;
   logic signed [2*W-1:0]        prod;
   logic [RW-1:0]                prod_res;
   logic [RW-1:0]                res_num_in, res_den_in;
   logic                         err_in;

   assign status.is_reduce = (op_ff == rar_pkg::OP_REDUCE);
   assign status.is_arith  = (op_ff == rar_pkg::OP_ADD) || (op_ff == rar_pkg::OP_SUBTRACT) ||
                             (op_ff == rar_pkg::OP_MULTIPLY) || (op_ff == rar_pkg::OP_DIVIDE);
   assign status.zero_both = (na_ff == '0) && (da_ff == '0);
   assign status.gcd_done  = (ga_ff == '0) || (gb_ff == '0);
   assign status.div_last  = (cnt_ff == '0);

   // Restoring division, one quotient bit per cycle in each lane.
   assign trial_n = {rem_n_ff, quo_n_ff[W-1]} - {1'b0, div_ff};
   assign trial_d = {rem_d_ff, quo_d_ff[W-1]} - {1'b0, div_ff};

   // One shared multiplier; the three steps produce the partial products
   // that every arithmetic opcode needs.
   always_comb begin
      case (cmd.mul_sel)
         rar_pkg::SEL_P0: begin
            mul_x = na_ff;
            mul_y = (op_ff == rar_pkg::OP_MULTIPLY) ? nb_ff : db_ff;
         end
         rar_pkg::SEL_P1: begin
            mul_x = da_ff;
            mul_y = nb_ff;
         end
         default: begin
            mul_x = da_ff;
            mul_y = db_ff;
         end
      endcase
   end

   assign prod     = mul_x * mul_y;
   assign prod_res = RW'(prod);

   always_comb begin
      res_num_in = '0;
      res_den_in = '0;
      err_in     = 1'b0;
      case (op_ff)
         rar_pkg::OP_REDUCE: begin
            if (status.zero_both) begin
               err_in = 1'b1;
            end else begin
               res_num_in = na_ff[W-1] ? (~RW'(quo_n_ff) + 1'b1) : RW'(quo_n_ff);
               res_den_in = da_ff[W-1] ? (~RW'(quo_d_ff) + 1'b1) : RW'(quo_d_ff);
            end
         end
         rar_pkg::OP_ADD: begin
            res_num_in = p0_ff + p1_ff;
            res_den_in = p2_ff;
         end
         rar_pkg::OP_SUBTRACT: begin
            res_num_in = p0_ff - p1_ff;
            res_den_in = p2_ff;
         end
         rar_pkg::OP_MULTIPLY: begin
            res_num_in = p0_ff;
            res_den_in = p2_ff;
         end
         rar_pkg::OP_DIVIDE: begin
            res_num_in = p0_ff;
            res_den_in = p1_ff;
         end
         default: begin
            res_num_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_tuser;
         na_ff <= req_tdata[W-1:0];
         da_ff <= req_tdata[2*W-1:W];
         nb_ff <= req_tdata[3*W-1:2*W];
         db_ff <= req_tdata[4*W-1:3*W];
         ga_ff <= mag_of(req_tdata[W-1:0]);
         gb_ff <= mag_of(req_tdata[2*W-1:W]);
         k_ff  <= '0;
      end

      // Binary GCD: strip common factors of two, then subtract odd values.
      if (cmd.gcd_step) begin
         if (!ga_ff[0] && !gb_ff[0]) begin
            ga_ff <= ga_ff >> 1;
            gb_ff <= gb_ff >> 1;
            k_ff  <= k_ff + 1'b1;
         end else if (!ga_ff[0]) begin
            ga_ff <= ga_ff >> 1;
         end else if (!gb_ff[0]) begin
            gb_ff <= gb_ff >> 1;
         end else if (ga_ff >= gb_ff) begin
            ga_ff <= ga_ff - gb_ff;
         end else begin
            gb_ff <= gb_ff - ga_ff;
         end
      end

      if (cmd.div_start) begin
         // One part is zero now, so the OR is the GCD shifted right by k.
         div_ff   <= (ga_ff | gb_ff) << k_ff;
         quo_n_ff <= mag_of(na_ff);
         quo_d_ff <= mag_of(da_ff);
         rem_n_ff <= '0;
         rem_d_ff <= '0;
         cnt_ff   <= KW'(W - 1);
      end

      if (cmd.div_step) begin
         if (!trial_n[W]) begin
            rem_n_ff <= trial_n[W-1:0];
            quo_n_ff <= {quo_n_ff[W-2:0], 1'b1};
         end else begin
            rem_n_ff <= {rem_n_ff[W-2:0], quo_n_ff[W-1]};
            quo_n_ff <= {quo_n_ff[W-2:0], 1'b0};
         end
         if (!trial_d[W]) begin
            rem_d_ff <= trial_d[W-1:0];
            quo_d_ff <= {quo_d_ff[W-2:0], 1'b1};
         end else begin
            rem_d_ff <= {rem_d_ff[W-2:0], quo_d_ff[W-1]};
            quo_d_ff <= {quo_d_ff[W-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
      end

      if (cmd.mul_step) begin
         case (cmd.mul_sel)
            rar_pkg::SEL_P0: p0_ff <= prod_res;
            rar_pkg::SEL_P1: p1_ff <= prod_res;
            default:         p2_ff <= prod_res;
         endcase
      end

      if (cmd.emit) begin
         res_num_ff <= res_num_in;
         res_den_ff <= res_den_in;
         err_ff     <= err_in;
      end
   end

   assign rsp_tdata = {{(rar_pkg::RSP_DATA_W - 2 * RW){1'b0}}, res_den_ff, res_num_ff};
   assign rsp_tuser = err_ff;

endmodule

// ----- src/rational_arith_reduce.sv -----
// Rational arithmetic unit over signed fractions a = num_a/den_a and b = num_b/den_b,
// one item at a time. Reduce divides both parts of a by the GCD of their magnitudes,
// keeping each part's sign; 0/0 returns 0/0 with error_flag set. Add, subtract,
// multiply and divide return unreduced cross products wrapped to 33 bits, and
// unused opcodes return zeros. An arithmetic item goes through a dispatch state,
// three passes through one shared multiplier and the output load. A reduce item
// goes through dispatch, the binary GCD steps and a bit-serial division that runs
// numerator and denominator in parallel over OPERAND_WIDTH quotient bits, then the
// output load; a 0/0 reduce and unused opcodes go from dispatch straight to the
// output load. The output load waits while a previous result is still offered.
// After it the block returns to idle and accepts the next item. A finished result
// waits in an output register, so the next item is accepted while it is pending.
module rational_arith_reduce #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF,
   localparam int ReqDataW = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ReqDataW-1:0]            req_tdata,  // num_a, den_a, num_b, den_b
   input  logic [rar_pkg::OPCODE_W-1:0]   req_tuser,  // opcode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rar_pkg::RSP_DATA_W-1:0] rsp_tdata,  // res_num, res_den
   output logic                           rsp_tuser   // error_flag
);

   rar_pkg::cmd_type    cmd;
   rar_pkg::status_type status;

   rar_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   rar_dp #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .status    (status),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ----- src/rar_checker.sv -----
`include "assert_macros.svh"

module rar_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rar_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);

   // A stalled result stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // An error result carries a zero numerator and denominator.
   `ASSERT_SAME(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)

   // Only one item is in work, so an accepted item closes the input side.
   `ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)

   // The padding bits above the two result fields are always zero.
   `ASSERT_SAME(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[rar_pkg::RSP_DATA_W-1:2*rar_pkg::RES_W] == '0)

endmodule

bind rational_arith_reduce rar_checker u_rar_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- tb/tb_rational_arith_reduce.sv -----
`timescale 1ns / 100ps

module tb_rational_arith_reduce;

   localparam int OW = rar_pkg::OPERAND_WIDTH_DEF;
   localparam int REQ_W = ((4 * OW + 7) / 8) * 8;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 120;
   localparam int RANDOM_ITEMS = 1800;
   localparam int N_DIRECTED = 25;

   // Opcodes the block does not define; they must return all zeros.
   localparam logic [rar_pkg::OPCODE_W-1:0] OP_SPARE_LO  = 3'd5;
   localparam logic [rar_pkg::OPCODE_W-1:0] OP_SPARE_MID = 3'd6;
   localparam logic [rar_pkg::OPCODE_W-1:0] OP_SPARE_HI  = 3'd7;

   typedef logic [rar_pkg::OPCODE_W-1:0] opcode_type;
   typedef logic signed [OW-1:0] operand_type;
   typedef logic signed [rar_pkg::RES_W-1:0] result_type;

   typedef struct {
      result_type num;
      result_type den;
      logic       err;
   } frac_result_type;

   typedef struct {
      opcode_type      op;
      operand_type     na;
      operand_type     da;
      operand_type     nb;
      operand_type     db;
      bit              fixed;
      frac_result_type want;
   } frac_item_type;

   typedef struct {
      opcode_type op;
      int         na;
      int         da;
      int         nb;
      int         db;
      bit         fixed;
      longint     rn;
      longint     rd;
      bit         err;
   } dir_row_type;

   // Rows with fixed set carry a result that is obvious by inspection; the rest
   // go through the predictor.
   dir_row_type dir_rows [N_DIRECTED] = '{
      '{rar_pkg::OP_REDUCE,        0,      0,      5,      7, 1,     0,  0, 1},
      '{rar_pkg::OP_REDUCE,        0,      5,      0,      0, 1,     0,  1, 0},
      '{rar_pkg::OP_REDUCE,        0,     -7,      0,      0, 1,     0, -1, 0},
      '{rar_pkg::OP_REDUCE,        9,      0,      0,      0, 1,     1,  0, 0},
      '{rar_pkg::OP_REDUCE,   -32768,      0,      1,      0, 1,    -1,  0, 0},
      '{rar_pkg::OP_REDUCE,   -32768, -32768,     -1,     -1, 1,    -1, -1, 0},
      '{rar_pkg::OP_REDUCE,    32767,  32767,      3,      4, 1,     1,  1, 0},
      '{rar_pkg::OP_REDUCE,       12,    -18,      0,      0, 0,     0,  0, 0},
      '{rar_pkg::OP_REDUCE,    32767, -32768,      0,      0, 0,     0,  0, 0},
      '{rar_pkg::OP_REDUCE,   -32768,  16384,      0,      0, 0,     0,  0, 0},
      '{rar_pkg::OP_REDUCE,        1,     -1,      0,      0, 1,     1, -1, 0},
      '{rar_pkg::OP_REDUCE,    32767,      1,      0,      0, 1, 32767,  1, 0},
      '{rar_pkg::OP_ADD,       32767, -32768,  32767, -32768, 0,     0,  0, 0},
      '{rar_pkg::OP_ADD,      -32768, -32768, -32768, -32768, 0,     0,  0, 0},
      '{rar_pkg::OP_ADD,           0,      0,      0,      0, 1,     0,  0, 0},
      '{rar_pkg::OP_SUBTRACT, -32768,  32767,  32767, -32768, 0,     0,  0, 0},
      '{rar_pkg::OP_SUBTRACT,      1,      2,      1,      2, 1,     0,  4, 0},
      '{rar_pkg::OP_MULTIPLY, -32768, -32768, -32768, -32768, 0,     0,  0, 0},
      '{rar_pkg::OP_MULTIPLY,  32767,      1, -32768,     -1, 0,     0,  0, 0},
      '{rar_pkg::OP_DIVIDE,        3,      4,      0,      5, 1,    15,  0, 0},
      '{rar_pkg::OP_DIVIDE,   -32768,  32767,  32767, -32768, 0,     0,  0, 0},
      '{rar_pkg::OP_DIVIDE,        0,      0,      0,      0, 1,     0,  0, 0},
      '{OP_SPARE_LO,             100,      3,      7,      9, 1,     0,  0, 0},
      '{OP_SPARE_MID,             -1,     -1,     -1,     -1, 1,     0,  0, 0},
      '{OP_SPARE_HI,           32767, -32768,  32767, -32768, 1,     0,  0, 0}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [REQ_W-1:0]               req_tdata = '0;  // num_a, den_a, num_b, den_b
   logic [rar_pkg::OPCODE_W-1:0]   req_tuser = '0;  // opcode
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [rar_pkg::RSP_DATA_W-1:0] rsp_tdata;       // res_num, res_den
   logic                           rsp_tuser;       // error_flag

   frac_item_type   stim_items [$];
   frac_result_type expected_fracs [$];
   int              feed_pos = 0;
   int              burst_left = 0;
   int              gap_left = 0;
   int              mismatches = 0;
   int              idle_cycles = 0;
   logic [15:0]     rx_pattern = 16'hffff;
   int              rx_epoch = 0;

   rational_arith_reduce #(
      .OPERAND_WIDTH(OW)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic frac_result_type fraction_result(input frac_item_type it);
      frac_result_type r;
      longint a, b, x, y, t, g;
      r.num = '0;
      r.den = '0;
      r.err = 1'b0;
      case (it.op)
         rar_pkg::OP_REDUCE: begin
            a = (it.na < 0) ? -longint'(it.na) : longint'(it.na);
            b = (it.da < 0) ? -longint'(it.da) : longint'(it.da);
            if (a == 0 && b == 0) begin
               r.err = 1'b1;
            end else begin
               // With one part zero the divisor is the other magnitude.
               if (a == 0 || b == 0) begin
                  g = a + b;
               end else begin
                  x = a;
                  y = b;
                  while (y != 0) begin
                     t = x % y;
                     x = y;
                     y = t;
                  end
                  g = x;
               end
               r.num = result_type'((it.na < 0) ? -(a / g) : (a / g));
               r.den = result_type'((it.da < 0) ? -(b / g) : (b / g));
            end
         end
         rar_pkg::OP_ADD: begin
            r.num = result_type'(longint'(it.na) * longint'(it.db)
                                 + longint'(it.da) * longint'(it.nb));
            r.den = result_type'(longint'(it.da) * longint'(it.db));
         end
         rar_pkg::OP_SUBTRACT: begin
            r.num = result_type'(longint'(it.na) * longint'(it.db)
                                 - longint'(it.da) * longint'(it.nb));
            r.den = result_type'(longint'(it.da) * longint'(it.db));
         end
         rar_pkg::OP_MULTIPLY: begin
            r.num = result_type'(longint'(it.na) * longint'(it.nb));
            r.den = result_type'(longint'(it.da) * longint'(it.db));
         end
         rar_pkg::OP_DIVIDE: begin
            r.num = result_type'(longint'(it.na) * longint'(it.db));
            r.den = result_type'(longint'(it.da) * longint'(it.nb));
         end
         default: ;
      endcase
      return r;
   endfunction

   // Extremes half the time, small values and full-range values for the rest.
   function automatic operand_type rand_operand();
      operand_type v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = {1'b1, {(OW - 1){1'b0}}};
         2: v = {1'b0, {(OW - 1){1'b1}}};
         3: v = '1;
         4: v = OW'(1);
         5, 6: v = OW'(int'($urandom_range(0, 128)) - 64);
         default: v = OW'($urandom);
      endcase
      return v;
   endfunction

   function automatic frac_item_type rand_item();
      frac_item_type it;
      int pick, f;
      pick = $urandom_range(0, 99);
      it.fixed = 1'b0;
      it.want = '{default: '0};
      it.nb = rand_operand();
      it.db = rand_operand();
      it.na = rand_operand();
      it.da = rand_operand();
      if (pick < 42) begin
         it.op = rar_pkg::OP_REDUCE;
         // Most reduce items share a factor so that the divisor is not trivial.
         if ($urandom_range(0, 9) < 6) begin
            f = $urandom_range(1, 200);
            it.na = OW'((int'($urandom_range(0, 300)) - 150) * f);
            it.da = OW'((int'($urandom_range(0, 300)) - 150) * f);
         end
      end else if (pick < 54) begin
         it.op = rar_pkg::OP_ADD;
      end else if (pick < 66) begin
         it.op = rar_pkg::OP_SUBTRACT;
      end else if (pick < 78) begin
         it.op = rar_pkg::OP_MULTIPLY;
      end else if (pick < 92) begin
         it.op = rar_pkg::OP_DIVIDE;
      end else begin
         it.op = opcode_type'($urandom_range(5, 7));
      end
      return it;
   endfunction

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin : feed
      int pos;
      pos = feed_pos;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (stim_items[pos].fixed) begin
               expected_fracs.push_back(stim_items[pos].want);
            end else begin
               expected_fracs.push_back(fraction_result(stim_items[pos]));
            end
            pos++;
            feed_pos <= pos;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pos < stim_items.size()) begin
               req_tvalid <= 1'b1;
               req_tdata <= REQ_W'({stim_items[pos].db, stim_items[pos].nb,
                                    stim_items[pos].da, stim_items[pos].na});
               req_tuser <= stim_items[pos].op;
               if (burst_left <= 1) begin
                  burst_left <= ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: a rotating ready mask that changes character every so often.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= rx_pattern[0];
         if (rx_epoch == 96) begin
            rx_epoch <= 0;
            case ($urandom_range(0, 3))
               0: rx_pattern <= 16'hffff;
               1: rx_pattern <= 16'($urandom);
               2: rx_pattern <= 16'h0001;
               default: rx_pattern <= 16'hf0f0;
            endcase
         end else begin
            rx_epoch <= rx_epoch + 1;
            rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
         end
      end
   end

   always @(posedge clock) begin : check
      frac_result_type want;
      result_type got_num, got_den;
      got_num = rsp_tdata[rar_pkg::RES_W-1:0];
      got_den = rsp_tdata[2*rar_pkg::RES_W-1:rar_pkg::RES_W];
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_fracs.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result item: num %0d den %0d err %0b",
                        got_num, got_den, rsp_tuser);
            mismatches++;
         end else begin
            want = expected_fracs.pop_front();
            if (got_num !== want.num || got_den !== want.den || rsp_tuser !== want.err) begin
               if (mismatches < 10)
                  $display("mismatch at %0t: expected %0d/%0d err %0b, got %0d/%0d err %0b",
                           $realtime, want.num, want.den, want.err,
                           got_num, got_den, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      frac_item_type it;
      for (int i = 0; i < N_DIRECTED; i++) begin
         it.op = dir_rows[i].op;
         it.na = OW'(dir_rows[i].na);
         it.da = OW'(dir_rows[i].da);
         it.nb = OW'(dir_rows[i].nb);
         it.db = OW'(dir_rows[i].db);
         it.fixed = dir_rows[i].fixed;
         it.want.num = result_type'(dir_rows[i].rn);
         it.want.den = result_type'(dir_rows[i].rd);
         it.want.err = dir_rows[i].err;
         stim_items.push_back(it);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++)
         stim_items.push_back(rand_item());

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (!(feed_pos == stim_items.size() && expected_fracs.size() == 0))
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_fracs.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/rar_pkg.sv
src/rar_ctrl.sv
src/rar_dp.sv
src/rational_arith_reduce.sv
src/rar_checker.sv
tb/tb_rational_arith_reduce.sv
